// File: rtl/fcc_pkg.sv
`timescale 1ns / 1ps

package fcc_pkg;

  localparam int DATA_W          = 8;
  localparam int ADDR_IN_W       = 16;
  localparam int TICK_W          = 24;
  localparam int CFG_W           = 24;
  localparam int CFG_IDX_W       = 2;
  localparam int SECTOR_BYTES    = 4096;
  localparam int SECTOR_W        = $clog2(SECTOR_BYTES);
  localparam int FLASH_BYTES_DEF = 131072;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_CHIP_ERASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_ERASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_CODE  = 2'd3;

  localparam logic [TICK_W-1:0] CHIP_ERASE_TICKS_RST   = 24'd1677721;
  localparam logic [TICK_W-1:0] SECTOR_ERASE_TICKS_RST = 24'd419430;
  localparam logic [TICK_W-1:0] PROGRAM_TICKS_RST      = 24'd335;
  localparam logic [DATA_W-1:0] DEVICE_CODE_RST        = 8'hD5;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;
  localparam logic [1:0] REQ_NONE  = 2'd3;

  localparam logic [ADDR_IN_W-1:0] ADDR_UNLOCK_A = 16'h5555;
  localparam logic [ADDR_IN_W-1:0] ADDR_UNLOCK_B = 16'h2AAA;

  localparam logic [DATA_W-1:0] CMD_UNLOCK_A     = 8'hAA;
  localparam logic [DATA_W-1:0] CMD_UNLOCK_B     = 8'h55;
  localparam logic [DATA_W-1:0] CMD_PROGRAM      = 8'hA0;
  localparam logic [DATA_W-1:0] CMD_ERASE        = 8'h80;
  localparam logic [DATA_W-1:0] CMD_SOFT_ID      = 8'h90;
  localparam logic [DATA_W-1:0] CMD_BANK         = 8'hB0;
  localparam logic [DATA_W-1:0] CMD_ID_EXIT      = 8'hF0;
  localparam logic [DATA_W-1:0] CMD_SECTOR_ERASE = 8'h30;
  localparam logic [DATA_W-1:0] CMD_CHIP_ERASE   = 8'h10;
  localparam logic [DATA_W-1:0] MFR_ID           = 8'hBF;
  localparam logic [DATA_W-1:0] STATUS_TOGGLE    = 8'h40;
  localparam logic [DATA_W-1:0] ERASED_BYTE      = 8'hFF;

  typedef enum logic [3:0] {
    M_IDLE,
    M_UNLOCK1,
    M_UNLOCK2,
    M_UNLOCK3,
    M_UNLOCK4,
    M_PROG_SETUP,
    M_ERASE_SETUP,
    M_BANK_SETUP,
    M_SOFT_ID,
    M_SECT_BUSY,
    M_CHIP_BUSY,
    M_PROG_BUSY
  } mode_t;

  typedef enum logic [1:0] {
    C_IDLE,
    C_EXEC,
    C_SWEEP,
    C_FINISH
  } ctrl_state_t;

  typedef struct packed {
    logic [1:0]           req_type;
    logic [ADDR_IN_W-1:0] address;
    logic [DATA_W-1:0]    write_data;
  } req_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              busy_res;
  } rsp_item_t;

  typedef struct packed {
    logic capture;
    logic sweep_en;
    logic commit;
    logic swept;
  } flash_cmd_t;

  typedef struct packed {
    logic need_sweep;
    logic sweep_last;
  } flash_status_t;

endpackage

// File: rtl/parallel_flash_command_controller.sv
// a request is captured, then executed; a held result or a sector sweep can delay the commit
// req_stall is high after capture until the request commits, so one request runs at a time
// a program into a sector erased since its last program first sweeps the sector to fill it with 0xFF
// reset: synchronous active-high; all sectors read as erased at once, no clearing pass
`timescale 1ns / 1ps

module parallel_flash_command_controller
  import fcc_pkg::*;
#(
  parameter int FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_item_t            req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_item_t            rsp,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  flash_cmd_t    cmd;
  flash_status_t status;

  fcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .cmd       (cmd)
  );

  fcc_dp #(
    .FLASH_BYTES (FLASH_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp       (rsp)
  );

endmodule

// File: rtl/fcc_dp.sv
`timescale 1ns / 1ps

module fcc_dp
  import fcc_pkg::*;
#(
  parameter int FLASH_BYTES = FLASH_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  req_item_t            req,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  flash_cmd_t           cmd,
  output flash_status_t        status,
  output rsp_item_t            rsp
);

  localparam int ADDR_W      = $clog2(FLASH_BYTES);
  localparam int NUM_SECTORS = FLASH_BYTES / SECTOR_BYTES;
  localparam int SEC_W       = ADDR_W - SECTOR_W;
  localparam logic HAS_BANKS = (ADDR_W > ADDR_IN_W);

  logic [TICK_W-1:0] chip_ticks;
  logic [TICK_W-1:0] sector_ticks;
  logic [TICK_W-1:0] prog_ticks;
  logic [DATA_W-1:0] dev_code;

  logic [DATA_W-1:0] cells [FLASH_BYTES];
  logic [DATA_W-1:0] rdata;

  req_item_t         req_q;
  logic [ADDR_W-1:0] idx_q;
  mode_t             mode;
  mode_t             mode_next;
  logic              bank;
  logic              bank_next;
  logic [TICK_W-1:0] elapsed;
  logic [TICK_W-1:0] elapsed_next;
  logic [TICK_W-1:0] busy_len;
  logic [TICK_W-1:0] busy_len_next;
  logic [DATA_W-1:0] status_byte;
  logic [DATA_W-1:0] status_byte_next;
  logic [NUM_SECTORS-1:0] erased;
  logic [SECTOR_W-1:0]    sweep_cnt;
  rsp_item_t              rsp_reg;

  logic [ADDR_IN_W:0] cap_full;
  logic [ADDR_W-1:0]  cap_idx;
  logic [SEC_W-1:0]   cur_sec;
  logic               sec_erased;
  logic [DATA_W-1:0]  cur_byte;
  logic               is_busy;
  logic               active;
  mode_t              eff_mode;
  logic               at_a;
  logic               at_b;
  logic [DATA_W-1:0]  rd;
  logic               wr_cell;
  logic               erase_sector;
  logic               erase_all;
  logic               clear_flag;
  logic [DATA_W-1:0]  prog_value;
  logic               busy_next;

  assign cap_full   = {bank, req.address};
  assign cap_idx    = cap_full[ADDR_W-1:0];
  assign cur_sec    = idx_q[ADDR_W-1 -: SEC_W];
  assign sec_erased = erased[cur_sec];
  assign cur_byte   = sec_erased ? ERASED_BYTE : rdata;
  assign prog_value = cur_byte & req_q.write_data;
  assign at_a       = (req_q.address == ADDR_UNLOCK_A);
  assign at_b       = (req_q.address == ADDR_UNLOCK_B);

  assign is_busy  = (mode == M_SECT_BUSY) || (mode == M_CHIP_BUSY) || (mode == M_PROG_BUSY);
  assign active   = is_busy && !((elapsed > busy_len) || (elapsed == TICK_MAX));
  assign eff_mode = is_busy ? M_IDLE : mode;

  always_comb begin
    mode_next        = mode;
    bank_next        = bank;
    elapsed_next     = elapsed;
    busy_len_next    = busy_len;
    status_byte_next = status_byte;
    rd               = '0;
    wr_cell          = 1'b0;
    erase_sector     = 1'b0;
    erase_all        = 1'b0;
    clear_flag       = 1'b0;
    unique case (req_q.req_type)
      REQ_READ: begin
        if (active) begin
          status_byte_next = status_byte ^ STATUS_TOGGLE;
          rd               = status_byte_next;
        end else if (eff_mode == M_SOFT_ID) begin
          mode_next = M_SOFT_ID;
          rd        = req_q.address[0] ? dev_code : MFR_ID;
        end else begin
          mode_next = M_IDLE;
          rd        = cur_byte;
        end
      end
      REQ_WRITE: begin
        if (!active) begin
          mode_next = eff_mode;
          unique case (eff_mode)
            M_IDLE: begin
              if (at_a && req_q.write_data == CMD_UNLOCK_A) begin
                mode_next = M_UNLOCK1;
              end
            end
            M_UNLOCK1: begin
              mode_next = (at_b && req_q.write_data == CMD_UNLOCK_B) ? M_UNLOCK2 : M_IDLE;
            end
            M_UNLOCK2: begin
              priority if (at_a && req_q.write_data == CMD_PROGRAM) begin
                mode_next = M_PROG_SETUP;
              end else if (at_a && req_q.write_data == CMD_ERASE) begin
                mode_next = M_UNLOCK3;
              end else if (at_a && req_q.write_data == CMD_SOFT_ID) begin
                mode_next = M_SOFT_ID;
              end else if (at_a && req_q.write_data == CMD_BANK) begin
                mode_next = M_BANK_SETUP;
              end else begin
                mode_next = M_IDLE;
              end
            end
            M_UNLOCK3: begin
              mode_next = (at_a && req_q.write_data == CMD_UNLOCK_A) ? M_UNLOCK4 : M_IDLE;
            end
            M_UNLOCK4: begin
              mode_next = (at_b && req_q.write_data == CMD_UNLOCK_B) ? M_ERASE_SETUP : M_IDLE;
            end
            M_SOFT_ID: begin
              priority if (req_q.write_data == CMD_ID_EXIT) begin
                mode_next = M_IDLE;
              end else if (at_a && req_q.write_data == CMD_UNLOCK_A) begin
                mode_next = M_UNLOCK1;
              end else begin
                mode_next = M_SOFT_ID;
              end
            end
            M_ERASE_SETUP: begin
              priority if (req_q.write_data == CMD_SECTOR_ERASE) begin
                erase_sector     = 1'b1;
                elapsed_next     = '0;
                busy_len_next    = sector_ticks;
                status_byte_next = '0;
                mode_next        = M_SECT_BUSY;
              end else if (at_a && req_q.write_data == CMD_CHIP_ERASE) begin
                erase_all        = 1'b1;
                elapsed_next     = '0;
                busy_len_next    = chip_ticks;
                status_byte_next = '0;
                mode_next        = M_CHIP_BUSY;
              end else begin
                mode_next = M_ERASE_SETUP;
              end
            end
            M_PROG_SETUP: begin
              wr_cell          = 1'b1;
              clear_flag       = sec_erased;
              elapsed_next     = '0;
              busy_len_next    = prog_ticks;
              status_byte_next = ~req_q.write_data;
              mode_next        = M_PROG_BUSY;
            end
            M_BANK_SETUP: begin
              bank_next = req_q.write_data[0] & HAS_BANKS;
              mode_next = M_IDLE;
            end
            default: begin
              mode_next = M_IDLE;
            end
          endcase
        end
      end
      REQ_TICK: begin
        if (elapsed != TICK_MAX) begin
          elapsed_next = elapsed + TICK_W'(1);
        end
      end
      REQ_NONE: begin
      end
    endcase
  end

  assign busy_next = ((mode_next == M_SECT_BUSY) || (mode_next == M_CHIP_BUSY) ||
                      (mode_next == M_PROG_BUSY)) &&
                     !((elapsed_next > busy_len_next) || (elapsed_next == TICK_MAX));

  assign status.need_sweep = wr_cell && sec_erased && !cmd.swept;
  assign status.sweep_last = &sweep_cnt;
  assign rsp               = rsp_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      chip_ticks   <= CHIP_ERASE_TICKS_RST;
      sector_ticks <= SECTOR_ERASE_TICKS_RST;
      prog_ticks   <= PROGRAM_TICKS_RST;
      dev_code     <= DEVICE_CODE_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_CHIP_ERASE:   chip_ticks   <= cfg_data;
        CFG_SECTOR_ERASE: sector_ticks <= cfg_data;
        CFG_PROGRAM:      prog_ticks   <= cfg_data;
        CFG_DEVICE_CODE:  dev_code     <= cfg_data[DATA_W-1:0];
      endcase
    end
  end

  // byte array: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.sweep_en) begin
      cells[{cur_sec, sweep_cnt}] <= ERASED_BYTE;
    end else if (cmd.commit && wr_cell) begin
      cells[idx_q] <= prog_value;
    end
    if (cmd.capture) begin
      rdata <= cells[cap_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q <= req;
      idx_q <= cap_idx;
    end
    if (cmd.commit) begin
      rsp_reg.read_data <= rd;
      rsp_reg.busy_res  <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= M_IDLE;
      bank        <= 1'b0;
      elapsed     <= '0;
      busy_len    <= '0;
      status_byte <= '0;
      erased      <= '1;
      sweep_cnt   <= '0;
    end else begin
      if (cmd.sweep_en) begin
        sweep_cnt <= sweep_cnt + SECTOR_W'(1);
      end
      if (cmd.commit) begin
        mode        <= mode_next;
        bank        <= bank_next;
        elapsed     <= elapsed_next;
        busy_len    <= busy_len_next;
        status_byte <= status_byte_next;
        if (erase_all) begin
          erased <= '1;
        end else if (erase_sector) begin
          erased[cur_sec] <= 1'b1;
        end else if (clear_flag) begin
          erased[cur_sec] <= 1'b0;
        end
      end
    end
  end

endmodule

// File: rtl/fcc_ctrl.sv
`timescale 1ns / 1ps

module fcc_ctrl
  import fcc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  input  flash_status_t status,
  output flash_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        rsp_valid_next;
  logic        out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE: begin
        if (req_valid) begin
          state_next = C_EXEC;
        end
      end
      C_EXEC: begin
        priority if (status.need_sweep) begin
          state_next = C_SWEEP;
        end else if (out_free) begin
          state_next = C_IDLE;
        end else begin
          state_next = C_EXEC;
        end
      end
      C_SWEEP: begin
        if (status.sweep_last) begin
          state_next = C_FINISH;
        end
      end
      C_FINISH: begin
        if (out_free) begin
          state_next = C_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    req_stall    = (state != C_IDLE);
    cmd.capture  = (state == C_IDLE) && req_valid;
    cmd.sweep_en = (state == C_SWEEP);
    cmd.swept    = (state == C_FINISH);
    cmd.commit   = (((state == C_EXEC) && !status.need_sweep) || (state == C_FINISH)) &&
                   out_free;
    rsp_valid_next = cmd.commit || (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= C_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!rsp_valid || !rsp_stall))
    else $error("commit while result register still held");

  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == C_SWEEP && !status.sweep_last) |=> (state == C_SWEEP))
    else $error("sector sweep left early");

  a_sweep_start: assert property (@(posedge clk) disable iff (rst)
    (state == C_EXEC && status.need_sweep) |=> (state == C_SWEEP && $past(!cmd.commit)))
    else $error("program into erased sector skipped the sweep");

  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == C_EXEC || state == C_FINISH))
    else $error("result raised outside execute");
`endif

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fcc_pkg::*;

  localparam int FLASH_BYTES    = FLASH_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;
  localparam int PHASE_ITEMS    = 190;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_item_t            req;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_item_t            rsp;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  rsp_item_t expected_bus_results[$];
  int        mismatches;
  int        requests_sent;
  int        sender_idle_pct;
  int        receiver_idle_pct;
  int        holds_asked;

  // flash image and command state as the block should hold them
  logic [DATA_W-1:0] flash_image [FLASH_BYTES];
  mode_t             flash_mode;
  logic              bank_sel;
  logic [TICK_W-1:0] ticks_elapsed;
  logic [TICK_W-1:0] op_length;
  logic [DATA_W-1:0] status_reg;
  logic [TICK_W-1:0] chip_erase_len;
  logic [TICK_W-1:0] sector_erase_len;
  logic [TICK_W-1:0] program_len;
  logic [DATA_W-1:0] device_id;

  parallel_flash_command_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit in_op_mode();
    return flash_mode inside {M_SECT_BUSY, M_CHIP_BUSY, M_PROG_BUSY};
  endfunction

  function automatic bit op_finished();
    return (ticks_elapsed > op_length) || (ticks_elapsed == TICK_MAX);
  endfunction

  function automatic bit flash_busy();
    return in_op_mode() && !op_finished();
  endfunction

  function automatic int cell_of(input logic [ADDR_IN_W-1:0] a);
    return ((int'(bank_sel) << 16) | int'(a)) & (FLASH_BYTES - 1);
  endfunction

  task automatic begin_op(input logic [TICK_W-1:0] len, input logic [DATA_W-1:0] st);
    ticks_elapsed = '0;
    op_length     = len;
    status_reg    = st;
  endtask

  task automatic reset_flash_state();
    foreach (flash_image[i]) flash_image[i] = ERASED_BYTE;
    flash_mode       = M_IDLE;
    bank_sel         = 1'b0;
    ticks_elapsed    = '0;
    op_length        = '0;
    status_reg       = '0;
    chip_erase_len   = CHIP_ERASE_TICKS_RST;
    sector_erase_len = SECTOR_ERASE_TICKS_RST;
    program_len      = PROGRAM_TICKS_RST;
    device_id        = DEVICE_CODE_RST;
  endtask

  task automatic flash_write(input logic [ADDR_IN_W-1:0] a, input logic [DATA_W-1:0] v);
    bit at_a;
    int base;
    int idx;
    at_a = (a == ADDR_UNLOCK_A);
    if (flash_busy()) return;
    if (in_op_mode()) flash_mode = M_IDLE;
    case (flash_mode)
      M_IDLE: begin
        if (at_a && v == CMD_UNLOCK_A) flash_mode = M_UNLOCK1;
      end
      M_UNLOCK1: begin
        flash_mode = (a == ADDR_UNLOCK_B && v == CMD_UNLOCK_B) ? M_UNLOCK2 : M_IDLE;
      end
      M_UNLOCK2: begin
        if (at_a && v == CMD_PROGRAM) flash_mode = M_PROG_SETUP;
        else if (at_a && v == CMD_ERASE) flash_mode = M_UNLOCK3;
        else if (at_a && v == CMD_SOFT_ID) flash_mode = M_SOFT_ID;
        else if (at_a && v == CMD_BANK) flash_mode = M_BANK_SETUP;
        else flash_mode = M_IDLE;
      end
      M_UNLOCK3: begin
        flash_mode = (at_a && v == CMD_UNLOCK_A) ? M_UNLOCK4 : M_IDLE;
      end
      M_UNLOCK4: begin
        flash_mode = (a == ADDR_UNLOCK_B && v == CMD_UNLOCK_B) ? M_ERASE_SETUP : M_IDLE;
      end
      M_SOFT_ID: begin
        if (v == CMD_ID_EXIT) flash_mode = M_IDLE;
        else if (at_a && v == CMD_UNLOCK_A) flash_mode = M_UNLOCK1;
      end
      M_ERASE_SETUP: begin
        if (v == CMD_SECTOR_ERASE) begin
          base = cell_of(a & ~16'(SECTOR_BYTES - 1));
          for (int i = 0; i < SECTOR_BYTES; i++) flash_image[base + i] = ERASED_BYTE;
          begin_op(sector_erase_len, '0);
          flash_mode = M_SECT_BUSY;
        end else if (v == CMD_CHIP_ERASE && at_a) begin
          foreach (flash_image[i]) flash_image[i] = ERASED_BYTE;
          begin_op(chip_erase_len, '0);
          flash_mode = M_CHIP_BUSY;
        end
      end
      M_PROG_SETUP: begin
        idx = cell_of(a);
        flash_image[idx] = flash_image[idx] & v;
        begin_op(program_len, ~v);
        flash_mode = M_PROG_BUSY;
      end
      M_BANK_SETUP: begin
        bank_sel   = v[0] & (FLASH_BYTES > 65536);
        flash_mode = M_IDLE;
      end
      default: flash_mode = M_IDLE;
    endcase
  endtask

  task automatic flash_predict(input req_item_t r, output rsp_item_t result);
    result = '0;
    case (r.req_type)
      REQ_READ: begin
        if (flash_busy()) begin
          status_reg       = status_reg ^ STATUS_TOGGLE;
          result.read_data = status_reg;
        end else begin
          if (in_op_mode()) flash_mode = M_IDLE;
          if (flash_mode == M_SOFT_ID) begin
            result.read_data = r.address[0] ? device_id : MFR_ID;
          end else begin
            flash_mode       = M_IDLE;
            result.read_data = flash_image[cell_of(r.address)];
          end
        end
      end
      REQ_WRITE: flash_write(r.address, r.write_data);
      REQ_TICK: begin
        if (ticks_elapsed != TICK_MAX) ticks_elapsed = ticks_elapsed + 1'b1;
      end
      default: ;
    endcase
    result.busy_res = flash_busy();
  endtask

  function automatic req_item_t make_req(input logic [1:0] kind, input logic [ADDR_IN_W-1:0] a,
                                         input logic [DATA_W-1:0] d);
    req_item_t r;
    r.req_type   = kind;
    r.address    = a;
    r.write_data = d;
    return r;
  endfunction

  task automatic send_request(input req_item_t item);
    rsp_item_t predicted;
    while ($urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    flash_predict(item, predicted);
    expected_bus_results.push_back(predicted);
    requests_sent++;
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
  endtask

  task automatic write_at(input logic [ADDR_IN_W-1:0] a, input logic [DATA_W-1:0] d);
    send_request(make_req(REQ_WRITE, a, d));
  endtask

  task automatic read_at(input logic [ADDR_IN_W-1:0] a);
    send_request(make_req(REQ_READ, a, 8'($urandom)));
  endtask

  task automatic tick_once();
    send_request(make_req(REQ_TICK, 16'($urandom), 8'($urandom)));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (expected_bus_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_CHIP_ERASE:   chip_erase_len   = value;
      CFG_SECTOR_ERASE: sector_erase_len = value;
      CFG_PROGRAM:      program_len      = value;
      CFG_DEVICE_CODE:  device_id        = value[DATA_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] chip, input logic [TICK_W-1:0] sector,
                            input logic [TICK_W-1:0] prog, input logic [DATA_W-1:0] dev);
    write_register(CFG_CHIP_ERASE, chip);
    write_register(CFG_SECTOR_ERASE, sector);
    write_register(CFG_PROGRAM, prog);
    write_register(CFG_DEVICE_CODE, CFG_W'(dev));
  endtask

  task automatic unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_UNLOCK_A);
    write_at(ADDR_UNLOCK_B, CMD_UNLOCK_B);
  endtask

  task automatic erase_prefix();
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_ERASE);
    unlock_cycle();
  endtask

  // mostly ticks, with status reads and ignored writes mixed in
  task automatic run_out_busy();
    int pick;
    while (flash_busy()) begin
      pick = $urandom_range(9);
      if (pick < 7) tick_once();
      else if (pick < 9) read_at(16'($urandom));
      else write_at(16'($urandom), 8'($urandom));
    end
  endtask

  task automatic seq_program();
    logic [ADDR_IN_W-1:0] a;
    a = 16'($urandom);
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_PROGRAM);
    write_at(a, 8'($urandom));
    run_out_busy();
    read_at(a);
  endtask

  task automatic seq_sector_erase();
    logic [ADDR_IN_W-1:0] a;
    a = 16'($urandom);
    erase_prefix();
    if ($urandom_range(3) == 0) write_at(16'($urandom), 8'($urandom));
    write_at(a, CMD_SECTOR_ERASE);
    run_out_busy();
    read_at(a);
  endtask

  task automatic seq_chip_erase();
    erase_prefix();
    write_at(ADDR_UNLOCK_A, CMD_CHIP_ERASE);
    run_out_busy();
    read_at(16'($urandom));
  endtask

  task automatic seq_soft_id();
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_SOFT_ID);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(2) == 0) write_at(16'($urandom), 8'($urandom));
      else read_at(16'($urandom));
    end
    if ($urandom_range(1) == 0) write_at(16'($urandom), CMD_ID_EXIT);
    else write_at(ADDR_UNLOCK_A, CMD_UNLOCK_A);
  endtask

  task automatic seq_bank_switch();
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_BANK);
    write_at(16'($urandom), 8'($urandom));
  endtask

  task automatic seq_broken();
    case ($urandom_range(3))
      0: begin
        write_at(ADDR_UNLOCK_A, CMD_UNLOCK_A);
        read_at(16'($urandom));
      end
      1: begin
        unlock_cycle();
        read_at(16'($urandom));
      end
      2: begin
        write_at(ADDR_UNLOCK_A, CMD_UNLOCK_A);
        write_at(16'($urandom), CMD_UNLOCK_B);
      end
      default: begin
        unlock_cycle();
        write_at(ADDR_UNLOCK_A, CMD_ERASE);
        if ($urandom_range(1) == 0) read_at(16'($urandom));
        else write_at(16'($urandom), 8'($urandom));
      end
    endcase
  endtask

  task automatic seq_noise();
    repeat ($urandom_range(1, 3))
      send_request(make_req(2'($urandom), 16'($urandom), 8'($urandom)));
  endtask

  task automatic run_random_phase(input int count);
    int start;
    int pick;
    start = requests_sent;
    while (requests_sent - start < count) begin
      pick = $urandom_range(99);
      if (pick < 35) seq_program();
      else if (pick < 45) seq_sector_erase();
      else if (pick < 47) seq_chip_erase();
      else if (pick < 59) seq_soft_id();
      else if (pick < 67) seq_bank_switch();
      else if (pick < 80) seq_broken();
      else seq_noise();
    end
    drain();
  endtask

  task automatic test_reset_contents();
    read_at(16'h0000);
    read_at(16'hFFFF);
  endtask

  task automatic test_software_id();
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_SOFT_ID);
    read_at(16'h0000);
    read_at(16'hFFFF);
    write_at(16'h1234, CMD_ID_EXIT);
    drain();
  endtask

  task automatic test_byte_program();
    set_timing(24'd0, 24'd0, 24'd0, 8'hFF);
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_PROGRAM);
    write_at(16'hFFFF, 8'h3C);
    read_at(16'hFFFF);
    read_at(16'hFFFF);
    write_at(16'hFFFF, 8'h00);
    tick_once();
    read_at(16'hFFFF);
    drain();
  endtask

  task automatic test_chip_erase();
    erase_prefix();
    write_at(ADDR_UNLOCK_A, CMD_CHIP_ERASE);
    tick_once();
    read_at(16'hFFFF);
    drain();
  endtask

  task automatic test_random_traffic();
    set_timing(24'($urandom_range(6)), 24'($urandom_range(6)), 24'($urandom_range(6)), 8'h00);
    sender_idle_pct   = 29;
    receiver_idle_pct = 85;
    run_random_phase(PHASE_ITEMS);
    set_timing(24'($urandom_range(6)), 24'($urandom_range(6)), 24'($urandom_range(6)), 8'hFF);
    sender_idle_pct   = 85;
    receiver_idle_pct = 29;
    run_random_phase(PHASE_ITEMS);
    set_timing(24'($urandom_range(6)), 24'($urandom_range(6)), 24'($urandom_range(6)),
               8'($urandom));
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random_phase(PHASE_ITEMS);
  endtask

  task automatic test_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    holds_asked++;
    run_random_phase(80);
  endtask

  // longest setting: the program stays busy to the end of the run
  task automatic test_longest_busy();
    set_timing(TICK_MAX, TICK_MAX, TICK_MAX, 8'($urandom));
    unlock_cycle();
    write_at(ADDR_UNLOCK_A, CMD_PROGRAM);
    write_at(16'($urandom), 8'($urandom));
    repeat (4) read_at(16'($urandom));
    repeat (4) tick_once();
    write_at(ADDR_UNLOCK_A, CMD_UNLOCK_A);
    read_at(16'($urandom));
    drain();
  endtask

  initial begin
    rst               = 1'b1;
    req_valid         = 1'b0;
    req               = '0;
    cfg_write         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    mismatches        = 0;
    requests_sent     = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    holds_asked       = 0;
    reset_flash_state();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_contents();
    test_software_id();
    test_byte_program();
    test_chip_erase();
    test_random_traffic();
    test_backpressure();
    test_longest_busy();

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && expected_bus_results.size() == 0) begin
      $display("parallel_flash_command_controller regression: pass");
    end else begin
      $display("parallel_flash_command_controller regression: fail");
    end
    $finish;
  end

  // response side: checks each result and drives the stall
  initial begin
    int        hold_left;
    int        holds_granted;
    rsp_item_t wanted;
    hold_left     = 0;
    holds_granted = 0;
    rsp_stall     = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (expected_bus_results.size() == 0) begin
          $display("%0t: unexpected result read_data=%h busy_res=%b", $time,
                   rsp.read_data, rsp.busy_res);
          mismatches++;
        end else begin
          wanted = expected_bus_results.pop_front();
          if (rsp.read_data !== wanted.read_data) begin
            $display("%0t: read_data expected %h actual %h", $time, wanted.read_data,
                     rsp.read_data);
            mismatches++;
          end
          if (rsp.busy_res !== wanted.busy_res) begin
            $display("%0t: busy_res expected %b actual %b", $time, wanted.busy_res,
                     rsp.busy_res);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else if (holds_granted != holds_asked) begin
        holds_granted++;
        hold_left = HOLD_CYCLES;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("parallel_flash_command_controller regression: fail");
    $finish;
  end

endmodule
